>>> src/mcfir_pkg.sv
// Shared constants and controller-to-datapath command type for the multichannel FIR filter.
package mcfir_pkg;

  localparam int NUM_TAPS_DEF     = 64;
  localparam int MAX_CHANNELS_DEF = 2;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 6;
  localparam int TAPS_W      = 7;
  localparam int CHANS_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS   = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd1;

  localparam logic [TAPS_W-1:0]  TAPS_RESET  = 7'd64;
  localparam logic [CHANS_W-1:0] CHANS_RESET = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  typedef struct packed {
    logic clr_we;
    logic start;
    logic stereo;
    logic coef_we;
    logic rd_en;
    logic s1_v;
    logic s1_first;
    logic s2_v;
    logic load_out;
  } cmd_t;

endpackage

>>> src/mcfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/mcfir_dp.sv
// Datapath: history and coefficient RAMs, per-lane multiply, truncate and accumulate, output register.
module mcfir_dp #(
  parameter int NUM_TAPS     = mcfir_pkg::NUM_TAPS_DEF,
  parameter int MAX_CHANNELS = mcfir_pkg::MAX_CHANNELS_DEF,
  localparam int AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1
) (
  input  logic                                  clk,
  input  mcfir_pkg::cmd_t                       cmd,
  input  logic [AW-1:0]                         rd_addr,
  input  logic [AW-1:0]                         wr_addr,
  input  logic [mcfir_pkg::COEF_IDX_W-1:0]      in_coef_index,
  input  logic signed [mcfir_pkg::COEF_W-1:0]   in_coef_value,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] in_sample_left,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] in_sample_right,
  output logic signed [mcfir_pkg::SAMPLE_W-1:0] out_filtered_left,
  output logic signed [mcfir_pkg::SAMPLE_W-1:0] out_filtered_right
);
  import mcfir_pkg::*;

  localparam int HW = SAMPLE_W * MAX_CHANNELS;

  logic                hist_we;
  logic [HW-1:0]       hist_wdata;
  logic [HW-1:0]       hist_rdata;
  logic [COEF_W-1:0]   coef_rdata;
  logic                stereo_r;

  logic signed [SAMPLE_W-1:0] samp_r  [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] carry_r [MAX_CHANNELS];
  logic signed [PROD_W-1:0]   prod_r  [MAX_CHANNELS];
  logic [SAMPLE_W-1:0]        acc_r   [MAX_CHANNELS];

  assign hist_we = cmd.clr_we || cmd.s1_v;

  mcfir_ram #(.WIDTH(HW), .DEPTH(NUM_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wr_addr),
    .wdata (hist_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (hist_rdata)
  );

  mcfir_ram #(.WIDTH(COEF_W), .DEPTH(NUM_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_we),
    .waddr (AW'(in_coef_index)),
    .wdata (in_coef_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stereo_r <= cmd.stereo;
    end
  end

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    logic signed [SAMPLE_W-1:0] samp_in;
    logic signed [SAMPLE_W-1:0] old_val;
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0]        quo;
    logic                       lane_on;

    assign samp_in = (c == 0) ? in_sample_left : in_sample_right;
    assign old_val = hist_rdata[SAMPLE_W*c +: SAMPLE_W];
    assign lane_on = (c == 0) || stereo_r;
    assign cur     = cmd.s1_first ? samp_r[c] : carry_r[c];
    assign prod    = cur * $signed(coef_rdata);
    assign quo     = prod_r[c][PROD_W-2:FRAC_BITS]
                   + SAMPLE_W'(prod_r[c][PROD_W-1] && (|prod_r[c][FRAC_BITS-1:0]));

    always_comb begin
      if (cmd.clr_we) begin
        hist_wdata[SAMPLE_W*c +: SAMPLE_W] = '0;
      end else if (lane_on) begin
        hist_wdata[SAMPLE_W*c +: SAMPLE_W] = cur;
      end else begin
        hist_wdata[SAMPLE_W*c +: SAMPLE_W] = old_val;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.start) begin
        samp_r[c] <= samp_in;
      end
      if (cmd.s1_v) begin
        carry_r[c] <= old_val;
        prod_r[c]  <= prod;
      end
      if (cmd.start) begin
        acc_r[c] <= '0;
      end else if (cmd.s2_v) begin
        acc_r[c] <= acc_r[c] + quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_filtered_left <= acc_r[0];
      if ((MAX_CHANNELS > 1) && stereo_r) begin
        out_filtered_right <= acc_r[MAX_CHANNELS-1];
      end else begin
        out_filtered_right <= '0;
      end
    end
  end

endmodule

>>> src/mcfir_ctrl.sv
// Controller: configuration registers, clearing pass, tap sequencer and handshakes.
module mcfir_ctrl #(
  parameter int NUM_TAPS     = mcfir_pkg::NUM_TAPS_DEF,
  parameter int MAX_CHANNELS = mcfir_pkg::MAX_CHANNELS_DEF,
  localparam int AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [mcfir_pkg::COEF_IDX_W-1:0]    in_coef_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mcfir_pkg::cmd_t                     cmd,
  output logic [AW-1:0]                       rd_addr,
  output logic [AW-1:0]                       wr_addr
);
  import mcfir_pkg::*;

  localparam int CW   = $clog2(NUM_TAPS + 1);
  localparam int CMPW = (CW > TAPS_W) ? CW : TAPS_W;
  localparam int IXW  = (CW > COEF_IDX_W) ? CW : COEF_IDX_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [TAPS_W-1:0]  taps_r;
  logic [CHANS_W-1:0] chans_r;
  logic               out_valid_r, out_valid_nxt;
  logic               s1_v_r, s1_first_r, s2_v_r;
  logic [AW-1:0]      s1_addr_r;

  logic [CMPW-1:0]    taps_ext;
  logic [CW-1:0]      taps_eff;
  logic               stereo;
  logic               run_last;
  logic               clr_last;
  logic               in_acc;
  logic               out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r  <= TAPS_RESET;
      chans_r <= CHANS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TAPS_IN_USE:  taps_r  <= cfg_data[TAPS_W-1:0];
        CFG_NUM_CHANNELS: chans_r <= cfg_data[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  assign taps_ext = CMPW'(taps_r);
  always_comb begin
    if (taps_ext == '0) begin
      taps_eff = CW'(1);
    end else if (taps_ext > CMPW'(NUM_TAPS)) begin
      taps_eff = CW'(NUM_TAPS);
    end else begin
      taps_eff = CW'(taps_ext);
    end
  end

  assign stereo   = (MAX_CHANNELS > 1) && (chans_r >= CHANS_W'(2));
  assign run_last = (CW'(cnt_r) == taps_eff - CW'(1));
  assign clr_last = (CW'(cnt_r) == CW'(NUM_TAPS - 1));
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.stereo    = stereo;
    cmd.s1_v      = s1_v_r;
    cmd.s1_first  = s1_first_r;
    cmd.s2_v      = s2_v_r;
    rd_addr       = cnt_r;
    wr_addr       = s1_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        wr_addr    = cnt_r;
        cnt_nxt    = cnt_r + AW'(1);
        if (clr_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.coef_we = (IXW'(in_coef_index) < IXW'(NUM_TAPS));
          end else begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + AW'(1);
        if (run_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= cmd.rd_en;
      s2_v_r      <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      s1_addr_r  <= cnt_r;
      s1_first_r <= (cnt_r == '0);
    end
  end

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside of finish state");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("product stage did not follow read stage");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (CW'(cnt_r) < taps_eff))
    else $error("tap read beyond active tap count");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!s1_v_r && !s2_v_r))
    else $error("finish reached with taps still in flight");

endmodule

>>> src/multichannel_fir_filter.sv
// Top level of the two-lane direct-form FIR filter with a shared coefficient table.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | req_type, coef_index, coef_value, samples
//   out_    | output    | out_valid/stall  | filtered_left, filtered_right
//   cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// A coefficient load gives no result.
// A sample frame walks the active taps (up to NUM_TAPS) one tap per cycle through the
// history and coefficient RAM read ports.
// After reset the history RAM is cleared while in_stall is high.
// A finished result waits in the output register; a new frame is taken meanwhile and
// holds in its finish state only if the previous result is still stalled.
module multichannel_fir_filter #(
  parameter int NUM_TAPS     = mcfir_pkg::NUM_TAPS_DEF,
  parameter int MAX_CHANNELS = mcfir_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_req_type,
  input  logic [mcfir_pkg::COEF_IDX_W-1:0]      in_coef_index,
  input  logic signed [mcfir_pkg::COEF_W-1:0]   in_coef_value,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] in_sample_left,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] in_sample_right,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mcfir_pkg::SAMPLE_W-1:0] out_filtered_left,
  output logic signed [mcfir_pkg::SAMPLE_W-1:0] out_filtered_right,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mcfir_pkg::*;

  localparam int AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

  cmd_t          cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  mcfir_ctrl #(.NUM_TAPS(NUM_TAPS), .MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_coef_index (in_coef_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr)
  );

  mcfir_dp #(.NUM_TAPS(NUM_TAPS), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .wr_addr            (wr_addr),
    .in_coef_index      (in_coef_index),
    .in_coef_value      (in_coef_value),
    .in_sample_left     (in_sample_left),
    .in_sample_right    (in_sample_right),
    .out_filtered_left  (out_filtered_left),
    .out_filtered_right (out_filtered_right)
  );

endmodule
